// File: rtl/point_in_polygon_test_defines.svh
// Assertion macros for the point-in-polygon block.
`ifndef POINT_IN_POLYGON_TEST_DEFINES_SVH
`define POINT_IN_POLYGON_TEST_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property once reset has gone away.
`define PPT_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("point_in_polygon_test assertion failed");

// Check a property on every edge, reset included.
`define PPT_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("point_in_polygon_test assertion failed");

`else

`define PPT_ASSERT(label, clk, rst, prop)
`define PPT_ASSERT_ALWAYS(label, clk, prop)

`endif

`endif

// File: rtl/ppt_pkg.sv
package ppt_pkg;

   // Default geometry
   localparam int MAX_VERTICES_DEF = 64;
   localparam int COORD_WIDTH_DEF  = 32;
   localparam int MIN_POLY_VERTICES = 3;

   // Field widths
   localparam int OP_W      = 2;
   localparam int ST_W      = 2;
   localparam int CNT_OUT_W = 7;

   typedef logic [OP_W-1:0] op_type;
   typedef logic [ST_W-1:0] status_type;

   // Operation codes
   localparam op_type OP_CLEAR  = 2'd0;
   localparam op_type OP_APPEND = 2'd1;
   localparam op_type OP_QUERY  = 2'd2;

   // Status codes
   localparam status_type ST_OK    = 2'd0;
   localparam status_type ST_FULL  = 2'd1;
   localparam status_type ST_SMALL = 2'd2;

endpackage

// File: rtl/ppt_req_if.sv
interface ppt_req_if #(
   parameter int COORD_WIDTH = ppt_pkg::COORD_WIDTH_DEF
);
   logic                          valid;
   logic                          ready;
   ppt_pkg::op_type               operation;
   logic signed [COORD_WIDTH-1:0] coord_x;
   logic signed [COORD_WIDTH-1:0] coord_y;

   modport source (output valid, output operation, output coord_x, output coord_y,
                   input ready);
   modport sink   (input valid, input operation, input coord_x, input coord_y,
                   output ready);
endinterface

// File: rtl/ppt_rsp_if.sv
interface ppt_rsp_if;
   logic                              valid;
   logic                              ready;
   logic                              inside_res;
   ppt_pkg::status_type               status;
   logic [ppt_pkg::CNT_OUT_W-1:0]     stored_vertices;

   modport source (output valid, output inside_res, output status,
                   output stored_vertices, input ready);
   modport sink   (input valid, input inside_res, input status,
                   input stored_vertices, output ready);
endinterface

// File: rtl/point_in_polygon_test.sv
// Even-odd ray-casting point-in-polygon test. Each request word clears the
// polygon, appends one vertex, or queries a point; every request gives one
// response word. Clear, append and a query on a polygon of fewer than three
// vertices are answered straight from idle. A full query makes, per edge,
// one vertex memory read and two passes through a single shared
// (COORD_WIDTH+1)-bit signed multiplier per edge, followed by a compare of
// the two cross products. Requests are not taken while a query runs, and a
// response waits in an output register until it is taken.
`include "point_in_polygon_test_defines.svh"

module point_in_polygon_test #(
   parameter int MAX_VERTICES = ppt_pkg::MAX_VERTICES_DEF,
   parameter int COORD_WIDTH  = ppt_pkg::COORD_WIDTH_DEF
) (
   input logic     clock,
   input logic     reset,
   ppt_req_if.sink   req_chan,
   ppt_rsp_if.source rsp_chan
);

   localparam int CNT_W = $clog2(MAX_VERTICES + 1);
   localparam int IDX_W = $clog2(MAX_VERTICES);
   localparam int DW    = COORD_WIDTH + 1;
   localparam int PW    = 2 * DW;
   localparam int OW    = ppt_pkg::CNT_OUT_W;

   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_LAST  = 4'd1;
   localparam logic [3:0] S_FIRST = 4'd2;
   localparam logic [3:0] S_FETCH = 4'd3;
   localparam logic [3:0] S_DIFF  = 4'd4;
   localparam logic [3:0] S_MUL_A = 4'd5;
   localparam logic [3:0] S_MUL_B = 4'd6;
   localparam logic [3:0] S_CMP   = 4'd7;
   localparam logic [3:0] S_RESP  = 4'd8;

   localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_VERTICES);
   localparam logic [CNT_W-1:0] CNT_MIN = CNT_W'(ppt_pkg::MIN_POLY_VERTICES);
   localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

   // Vertex store
   logic signed [COORD_WIDTH-1:0] vx_mem [MAX_VERTICES];
   logic signed [COORD_WIDTH-1:0] vy_mem [MAX_VERTICES];
   logic signed [COORD_WIDTH-1:0] rd_x_ff, rd_y_ff;
   logic                          mem_we;

   // Control
   logic [3:0]       state_ff, state_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic             inside_ff, inside_in;

   // Query datapath
   logic signed [COORD_WIDTH-1:0] px_ff, px_in, py_ff, py_in;
   logic signed [COORD_WIDTH-1:0] bx_ff, bx_in, by_ff, by_in;
   logic signed [DW-1:0]          dxp_ff, dxp_in, dy_ff, dy_in;
   logic signed [DW-1:0]          dxb_ff, dxb_in, dyp_ff, dyp_in;
   logic                          straddle_ff, straddle_in;
   logic signed [PW-1:0]          lhs_ff, lhs_in, rhs_ff, rhs_in;
   logic signed [DW-1:0]          mul_a, mul_b;
   logic signed [PW-1:0]          prod;
   logic                          crossing;

   // Response register
   logic                     rsp_valid_ff, rsp_valid_in;
   logic                     rsp_inside_ff, rsp_inside_in;
   ppt_pkg::status_type      rsp_status_ff, rsp_status_in;
   logic [OW-1:0]            rsp_cnt_ff, rsp_cnt_in;
   logic [CNT_W+OW-1:0]      cnt_ext;

   logic rsp_free;
   logic req_fire;
   logic append_fit;

   assign rsp_free = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == S_IDLE) && rsp_free;
   assign req_fire = req_chan.valid && req_chan.ready;
   assign append_fit = req_fire && (req_chan.operation == ppt_pkg::OP_APPEND)
                       && (count_ff < CNT_MAX);

   // Shared multiplier: first pass (px-ax)*dy, second pass (bx-ax)*(py-ay)
   assign mul_a = (state_ff == S_MUL_A) ? dxp_ff : dxb_ff;
   assign mul_b = (state_ff == S_MUL_A) ? dy_ff : dyp_ff;
   assign prod  = mul_a * mul_b;

   // Crossing lies right of the point; compare direction follows sign of dy
   assign crossing = straddle_ff && (dy_ff[DW-1] ? (rhs_ff < lhs_ff) : (lhs_ff < rhs_ff));

   always_comb begin
      state_in      = state_ff;
      count_in      = count_ff;
      idx_in        = idx_ff;
      inside_in     = inside_ff;
      px_in         = px_ff;
      py_in         = py_ff;
      bx_in         = bx_ff;
      by_in         = by_ff;
      dxp_in        = dxp_ff;
      dy_in         = dy_ff;
      dxb_in        = dxb_ff;
      dyp_in        = dyp_ff;
      straddle_in   = straddle_ff;
      lhs_in        = lhs_ff;
      rhs_in        = rhs_ff;
      rsp_valid_in  = rsp_valid_ff && !rsp_chan.ready;
      rsp_inside_in = rsp_inside_ff;
      rsp_status_in = rsp_status_ff;
      rsp_cnt_in    = rsp_cnt_ff;
      mem_we        = 1'b0;
      cnt_ext       = {{OW{1'b0}}, count_ff};

      unique case (state_ff)
         S_IDLE: begin
            if (req_fire) begin
               rsp_valid_in  = 1'b1;
               rsp_inside_in = 1'b0;
               rsp_status_in = ppt_pkg::ST_OK;
               rsp_cnt_in    = cnt_ext[OW-1:0];
               case (req_chan.operation)
                  ppt_pkg::OP_CLEAR: begin
                     count_in   = '0;
                     rsp_cnt_in = '0;
                  end
                  ppt_pkg::OP_APPEND: begin
                     if (count_ff < CNT_MAX) begin
                        mem_we     = 1'b1;
                        count_in   = count_ff + CNT_ONE;
                        cnt_ext    = {{OW{1'b0}}, count_ff + CNT_ONE};
                        rsp_cnt_in = cnt_ext[OW-1:0];
                     end else begin
                        rsp_status_in = ppt_pkg::ST_FULL;
                     end
                  end
                  ppt_pkg::OP_QUERY: begin
                     if (count_ff < CNT_MIN) begin
                        rsp_status_in = ppt_pkg::ST_SMALL;
                     end else begin
                        // hold the response until the walk is done
                        rsp_valid_in = 1'b0;
                        px_in        = req_chan.coord_x;
                        py_in        = req_chan.coord_y;
                        idx_in       = count_ff - CNT_ONE;
                        inside_in    = 1'b0;
                        state_in     = S_LAST;
                     end
                  end
                  default: begin
                  end
               endcase
            end
         end
         S_LAST: begin
            // last vertex is read out of memory this cycle
            state_in = S_FIRST;
         end
         S_FIRST: begin
            bx_in    = rd_x_ff;
            by_in    = rd_y_ff;
            idx_in   = '0;
            state_in = S_FETCH;
         end
         S_FETCH: begin
            state_in = S_DIFF;
         end
         S_DIFF: begin
            dxp_in      = DW'(px_ff) - DW'(rd_x_ff);
            dy_in       = DW'(by_ff) - DW'(rd_y_ff);
            dxb_in      = DW'(bx_ff) - DW'(rd_x_ff);
            dyp_in      = DW'(py_ff) - DW'(rd_y_ff);
            straddle_in = (rd_y_ff > py_ff) != (by_ff > py_ff);
            // current vertex becomes predecessor of the next edge
            bx_in       = rd_x_ff;
            by_in       = rd_y_ff;
            idx_in      = idx_ff + CNT_ONE;
            state_in    = S_MUL_A;
         end
         S_MUL_A: begin
            lhs_in   = prod;
            state_in = S_MUL_B;
         end
         S_MUL_B: begin
            rhs_in   = prod;
            state_in = S_CMP;
         end
         S_CMP: begin
            inside_in = inside_ff ^ crossing;
            state_in  = (idx_ff == count_ff) ? S_RESP : S_FETCH;
         end
         S_RESP: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_inside_in = inside_ff;
               rsp_status_in = ppt_pkg::ST_OK;
               rsp_cnt_in    = cnt_ext[OW-1:0];
               state_in      = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Vertex memory: write on append, registered read at the walk index
   always_ff @(posedge clock) begin
      if (mem_we) begin
         vx_mem[count_ff[IDX_W-1:0]] <= req_chan.coord_x;
         vy_mem[count_ff[IDX_W-1:0]] <= req_chan.coord_y;
      end
      rd_x_ff <= vx_mem[idx_ff[IDX_W-1:0]];
      rd_y_ff <= vy_mem[idx_ff[IDX_W-1:0]];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         inside_ff    <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         inside_ff    <= inside_in;
      end
   end

   always_ff @(posedge clock) begin
      idx_ff        <= idx_in;
      px_ff         <= px_in;
      py_ff         <= py_in;
      bx_ff         <= bx_in;
      by_ff         <= by_in;
      dxp_ff        <= dxp_in;
      dy_ff         <= dy_in;
      dxb_ff        <= dxb_in;
      dyp_ff        <= dyp_in;
      straddle_ff   <= straddle_in;
      lhs_ff        <= lhs_in;
      rhs_ff        <= rhs_in;
      rsp_inside_ff <= rsp_inside_in;
      rsp_status_ff <= rsp_status_in;
      rsp_cnt_ff    <= rsp_cnt_in;
   end

   assign rsp_chan.valid           = rsp_valid_ff;
   assign rsp_chan.inside_res      = rsp_inside_ff;
   assign rsp_chan.status          = rsp_status_ff;
   assign rsp_chan.stored_vertices = rsp_cnt_ff;

   // Count stays within the store
   `PPT_ASSERT(a_count_bound, clock, reset, count_ff <= CNT_MAX)

   // A running query always has at least three stored vertices behind it
   `PPT_ASSERT(a_query_min, clock, reset, (state_ff != S_IDLE) |-> (count_ff >= CNT_MIN))

   // An append that fits grows the count by one
   `PPT_ASSERT(a_append_grow, clock, reset, append_fit |=> (count_ff == $past(count_ff) + CNT_ONE))

   // Reset leaves no response pending
   `PPT_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (!rsp_valid_ff && (state_ff == S_IDLE)))

endmodule
